/* rtl/core/tah_pkg.sv */
package tah_pkg;

    // Field widths fixed by the item and register formats
    localparam int TEMP_W     = 14;
    localparam int TARGET_W   = 12;
    localparam int TRIG_W     = 11;
    localparam int BAND_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Build defaults
    localparam int AVG_DEPTH_DEF = 32;
    localparam int ADC_BITS_DEF  = 10;
    localparam int SUM_W_DEF     = TEMP_W + 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TARGET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_DEADBAND  = 2'd3;

    // Register reset values
    localparam logic signed [TARGET_W-1:0] MIN_TARGET_RST     = 12'sd0;
    localparam logic signed [TARGET_W-1:0] MAX_TARGET_RST     = 12'sd640;
    localparam logic        [TRIG_W-1:0]   TRIGGER_OFFSET_RST = 11'd48;
    localparam logic        [BAND_W-1:0]   KNOB_DEADBAND_RST  = 10'd25;

    // Result layout, lowest bit first
    localparam int OUT_RELAY_BIT = 0;
    localparam int OUT_AVG_LSB   = 1;
    localparam int OUT_TGT_LSB   = OUT_AVG_LSB + TEMP_W;
    localparam int OUT_CHG_BIT   = OUT_TGT_LSB + TARGET_W;
    localparam int OUT_SKIP_BIT  = OUT_CHG_BIT + 1;
    localparam int OUT_FIELD_W   = OUT_SKIP_BIT + 1;
    localparam int M_TDATA_W     = ((OUT_FIELD_W + 7) / 8) * 8;

    // log2 in Q30: integer part from the leading one, fraction by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [63:0] n);
        logic [63:0] y;
        logic [63:0] frac;
        int          k;
        k    = 0;
        frac = '0;
        for (int i = 0; i < 31; i++) begin
            if ((n >> (i + 1)) != 64'd0) k = i + 1;
        end
        y = n << (30 - k);
        for (int i = 0; i < 30; i++) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y           = y >> 1;
                frac[29-i] = 1'b1;
            end
        end
        return (64'(k) << 30) | frac;
    endfunction

    // unsigned quotient by restoring long division, one bit per step
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Steinhart-Hart conversion of one thermistor code to 1/16 degree C
    function automatic logic signed [TEMP_W-1:0] code_to_temp(
        input int unsigned code,
        input int unsigned full_scale
    );
        logic [63:0] g;
        logic [63:0] l;
        logic [63:0] n;
        logic [63:0] kel;
        longint      r;
        longint      t;
        if (code == 0) return '0;
        if (code >= full_scale) begin
            kel = 64'd0;
        end else begin
            g = log2_q30(64'd10000) + log2_q30(64'(full_scale - code))
                - log2_q30(64'(code));
            l = ((g >> 14) * 64'd744261118) >> 30;
            n = 64'd13281911480000 + ((64'd2000112940000 * l) >> 16)
                + ((64'd2350560518 * ((l * l * l) >> 32)) >> 16);
            kel = udiv64(64'd16000000000000000000, n);
        end
        r = longint'(kel) - 64'sd436990;
        if (r >= 0) t = longint'(udiv64(64'(r), 64'd100));
        else        t = -longint'(udiv64(64'(-r + 64'sd99), 64'd100));
        return TEMP_W'(t);
    endfunction

endpackage

/* rtl/core/tah_floor_div.sv */
module tah_floor_div #(
    parameter int XW      = tah_pkg::SUM_W_DEF,
    parameter int DIVISOR = tah_pkg::AVG_DEPTH_DEF
) (
    input  logic signed [XW-1:0] x,
    output logic signed [XW-1:0] q
);

    // Floor division of a signed value by a constant
    localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

    generate
        if (IS_POW2) begin : g_shift
            localparam int SHIFT = $clog2(DIVISOR);
            assign q = x >>> SHIFT;
        end else begin : g_recip
            // reciprocal underestimates the quotient by at most one
            localparam longint unsigned MULT = (64'd1 << XW) / DIVISOR;
            localparam logic [XW-1:0]   D_V  = XW'(DIVISOR);
            localparam logic [XW-1:0]   M_V  = XW'(MULT);

            logic          neg;
            logic [XW-1:0]   ax;
            logic [2*XW-1:0] full;
            logic [XW-1:0]   q0;
            logic [XW-1:0]   rem;
            logic            fix;
            logic [XW-1:0]   qa;
            logic            rem_nz;

            always_comb begin
                neg    = x[XW-1];
                ax     = neg ? XW'(-x) : XW'(x);
                full   = (2*XW)'(ax) * (2*XW)'(M_V);
                q0     = full[2*XW-1:XW];
                rem    = ax - XW'(q0 * D_V);
                fix    = rem >= D_V;
                qa     = q0 + XW'(fix);
                rem_nz = fix ? (rem != D_V) : (rem != '0);
                // round toward minus infinity on negative input
                if (neg) q = rem_nz ? signed'(~qa) : signed'(-qa);
                else     q = signed'(qa);
            end
        end
    endgenerate

endmodule

/* rtl/core/thermostat_average_hysteresis.sv */
// Hysteresis thermostat with a moving average of the temperature.
//
// Input stream (s_*): one request per control pass, carrying a thermistor ADC
// code and a knob ADC code. A thermistor code of zero skips the temperature
// update and relay decision; the knob is still evaluated.
// Result stream (m_*): exactly one result per request, in order: relay state,
// floored average temperature, current target and the changed/skipped flags.
// Configuration (cfg_*): register writes by index, always ready; write only
// while no request is in flight.
//
// Throughput: one request per cycle while the result is not stalled. The first
// stage reads the conversion ROM and the ring entry to be replaced and forms the
// knob product; the second updates the running sum, relay, target and loads the
// result register.
//
// Reset: synchronous, active low. The ring reads as zero through per-entry
// valid bits, so no clearing pass is needed and requests are taken at once.
// A stalled result holds in the output register; one more request waits in
// the first stage, after which s_tready drops until the result is taken.
module thermostat_average_hysteresis #(
    parameter int AVG_DEPTH = tah_pkg::AVG_DEPTH_DEF,
    parameter int ADC_BITS  = tah_pkg::ADC_BITS_DEF,
    localparam int S_TDATA_W = ((2 * ADC_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: thermistor_code, knob_code
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_TDATA_W-1:0]                s_tdata,
    // m_tdata: relay_on, average_temp, target_temp, target_changed, sample_skipped
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tah_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tah_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tah_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    import tah_pkg::*;

    localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
    localparam int ROM_DEPTH  = 1 << ADC_BITS;
    localparam int POS_W      = $clog2(AVG_DEPTH);
    localparam int SUM_W      = TEMP_W + $clog2(AVG_DEPTH);
    localparam int CMP_W      = SUM_W + 1;
    localparam int TSUM_W     = TARGET_W + 1;
    localparam int SPAN_W     = TARGET_W + 1;
    localparam int PROD_W     = ADC_BITS + 1 + SPAN_W;
    localparam int KW         = (ADC_BITS > BAND_W) ? ADC_BITS : BAND_W;

    localparam logic [POS_W-1:0]        POS_LAST = POS_W'(AVG_DEPTH - 1);
    localparam logic signed [CMP_W-1:0] DEPTH_S  = CMP_W'(AVG_DEPTH);

    typedef logic [ROM_DEPTH-1:0][TEMP_W-1:0] rom_t;

    function automatic rom_t build_rom();
        rom_t rom;
        for (int c = 0; c < ROM_DEPTH; c++) begin
            rom[c] = code_to_temp(c, FULL_SCALE);
        end
        return rom;
    endfunction

    // code to temperature, 1/16 degree C
    localparam rom_t TEMP_ROM = build_rom();

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic signed [TARGET_W-1:0] min_target_reg;
    logic signed [TARGET_W-1:0] max_target_reg;
    logic        [TRIG_W-1:0]   trigger_offset_reg;
    logic        [BAND_W-1:0]   knob_deadband_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_target_reg     <= MIN_TARGET_RST;
            max_target_reg     <= MAX_TARGET_RST;
            trigger_offset_reg <= TRIGGER_OFFSET_RST;
            knob_deadband_reg  <= KNOB_DEADBAND_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_TARGET:     min_target_reg     <= signed'(cfg_wdata[TARGET_W-1:0]);
                REG_MAX_TARGET:     max_target_reg     <= signed'(cfg_wdata[TARGET_W-1:0]);
                REG_TRIGGER_OFFSET: trigger_offset_reg <= cfg_wdata[TRIG_W-1:0];
                REG_KNOB_DEADBAND:  knob_deadband_reg  <= cfg_wdata[BAND_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake and stage control
    // ---------------------------------------------------------------------
    logic                s1_valid_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                in_take;
    logic                s2_adv;

    // advance the second stage whenever the output register is free or drains
    assign s2_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s2_adv;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic [ADC_BITS-1:0] in_therm;
    logic [ADC_BITS-1:0] in_knob;

    assign in_therm = s_tdata[ADC_BITS-1:0];
    assign in_knob  = s_tdata[2*ADC_BITS-1:ADC_BITS];

    // ---------------------------------------------------------------------
    // Persistent state
    // ---------------------------------------------------------------------
    logic signed [TEMP_W-1:0]   ring_mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0]       ring_vld_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [POS_W-1:0]           wpos_reg;
    logic                       relay_reg;
    logic [ADC_BITS-1:0]        last_knob_reg;
    logic signed [TARGET_W-1:0] target_reg;

    // ---------------------------------------------------------------------
    // Stage 1: ROM read, ring read, knob product
    // ---------------------------------------------------------------------
    logic                      s1_skip_reg;
    logic signed [TEMP_W-1:0]  s1_temp_reg;
    logic signed [TEMP_W-1:0]  s1_old_reg;
    logic                      s1_old_vld_reg;
    logic [ADC_BITS-1:0]       s1_knob_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg;

    logic [POS_W-1:0]          wpos_inc;
    logic [POS_W-1:0]          rd_pos;
    logic signed [SPAN_W-1:0]  span;
    logic signed [PROD_W-1:0]  knob_prod;

    assign wpos_inc = (wpos_reg == POS_LAST) ? '0 : wpos_reg + POS_W'(1);
    // the request leaving stage 1 this cycle moves the write position first
    assign rd_pos   = (s1_valid_reg && !s1_skip_reg) ? wpos_inc : wpos_reg;
    assign span     = SPAN_W'(max_target_reg) - SPAN_W'(min_target_reg);
    assign knob_prod = PROD_W'(signed'({1'b0, in_knob})) * PROD_W'(span);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_take) begin
            s1_valid_reg <= 1'b1;
        end else if (s2_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_skip_reg    <= (in_therm == '0);
            s1_temp_reg    <= signed'(TEMP_ROM[in_therm]);
            s1_old_reg     <= ring_mem[rd_pos];
            s1_old_vld_reg <= ring_vld_reg[rd_pos];
            s1_knob_reg    <= in_knob;
            s1_prod_reg    <= knob_prod;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: running sum, relay, knob, result
    // ---------------------------------------------------------------------
    logic signed [TEMP_W-1:0]   old_temp;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [CMP_W-1:0]    sum_cmp;
    logic signed [TSUM_W-1:0]   on_level;
    logic signed [CMP_W-1:0]    thr_on;
    logic signed [CMP_W-1:0]    thr_off;
    logic                       relay_next;
    logic [ADC_BITS-1:0]        knob_diff;
    logic                       knob_move;
    logic signed [PROD_W-1:0]   knob_q;
    logic signed [TARGET_W-1:0] target_next;
    logic signed [SUM_W-1:0]    avg_q;
    logic signed [TEMP_W-1:0]   avg_temp;
    logic [M_TDATA_W-1:0]       m_tdata_next;

    tah_floor_div #(
        .XW      (PROD_W),
        .DIVISOR (FULL_SCALE)
    ) u_knob_div (
        .x (s1_prod_reg),
        .q (knob_q)
    );

    tah_floor_div #(
        .XW      (SUM_W),
        .DIVISOR (AVG_DEPTH)
    ) u_avg_div (
        .x (sum_next),
        .q (avg_q)
    );

    always_comb begin
        // an entry never written reads as zero
        old_temp = s1_old_vld_reg ? s1_old_reg : '0;
        sum_next = s1_skip_reg ? sum_reg
                               : sum_reg + SUM_W'(s1_temp_reg) - SUM_W'(old_temp);
        sum_cmp  = CMP_W'(sum_next);
        on_level = TSUM_W'(target_reg) + signed'(TSUM_W'(trigger_offset_reg));
        thr_on   = DEPTH_S * CMP_W'(on_level);
        thr_off  = DEPTH_S * CMP_W'(target_reg);

        // switch on above target plus offset, off below target, hold between
        if (s1_skip_reg) relay_next = relay_reg;
        else if (relay_reg) relay_next = !(sum_cmp < thr_off);
        else relay_next = sum_cmp > thr_on;

        knob_diff = (s1_knob_reg > last_knob_reg) ? s1_knob_reg - last_knob_reg
                                                  : last_knob_reg - s1_knob_reg;
        knob_move = KW'(knob_diff) > KW'(knob_deadband_reg);
        target_next = knob_move ? min_target_reg + TARGET_W'(knob_q) : target_reg;

        avg_temp = TEMP_W'(avg_q);
        m_tdata_next = M_TDATA_W'({s1_skip_reg, knob_move, target_next, avg_temp,
                                   relay_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg  <= '0;
            sum_reg       <= '0;
            wpos_reg      <= '0;
            relay_reg     <= 1'b0;
            last_knob_reg <= '0;
            target_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (s2_adv) begin
                sum_reg    <= sum_next;
                relay_reg  <= relay_next;
                target_reg <= target_next;
                if (!s1_skip_reg) begin
                    ring_vld_reg[wpos_reg] <= 1'b1;
                    wpos_reg               <= wpos_inc;
                end
                if (knob_move) begin
                    last_knob_reg <= s1_knob_reg;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && !s1_skip_reg) begin
            ring_mem[wpos_reg] <= s1_temp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_skip_holds_relay: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_adv && s1_skip_reg |=> relay_reg == $past(relay_reg))
        else $error("relay moved on a skipped pass");

    a_skip_holds_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_adv && s1_skip_reg |=> $stable(sum_reg) && $stable(wpos_reg))
        else $error("running sum or write position moved on a skipped pass");

    a_relay_on_above: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(relay_reg) |-> $past(s2_adv && (sum_cmp > thr_on)))
        else $error("relay switched on without the sum above the on level");

    a_target_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (target_reg != $past(target_reg)) |-> m_tvalid_reg && m_tdata_reg[OUT_CHG_BIT])
        else $error("target changed without the changed flag");

endmodule
